FILE: rtl/pih_pkg.sv
// Shared constants, state encoding and histogram memory request type
// for the pulse interval histogram. No dependencies.
package pih_pkg;

  localparam int unsigned MaxBuckets   = 1024;
  localparam int unsigned Tracks       = 9;
  localparam int unsigned PositionBits = 32;

  localparam int unsigned BucketIdxW = $clog2(MaxBuckets);
  localparam int unsigned ScanIdxW   = BucketIdxW + 1;
  localparam int unsigned TrackIdxW  = (Tracks > 1) ? $clog2(Tracks) : 1;
  localparam int unsigned CfgW       = 11;
  localparam int unsigned CountW     = 32;
  localparam int unsigned IntervalW  = 10;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } pih_state_e;

  // requests to the histogram memory in the current cycle
  typedef struct packed {
    logic                  we;
    logic [BucketIdxW-1:0] waddr;
    logic [CountW-1:0]     wdata;
    logic                  re;
    logic [BucketIdxW-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/pih_hist_ram.sv
// Histogram count memory: one write port, one read port, registered read.
// Depends on pih_pkg for depth, widths and the request struct.
module pih_hist_ram (
  input  logic                     clk_i,
  input  pih_pkg::ram_req_t        req_i,
  output logic [pih_pkg::CountW-1:0] rd_data_o
);
  import pih_pkg::*;

  logic [CountW-1:0] mem [MaxBuckets];
  logic [CountW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/pulse_interval_histogram.sv
// Top level of the pulse interval histogram: sequencer, track edge unit
// and mode scan. Depends on pih_pkg and pih_hist_ram.
//
// Usage: samples arrive on the s_axis channel, one 9-track sample per
// request, with tlast on the final sample of a tape. Rising edges are
// timed against each track's previous edge and the intervals build a
// histogram. After the tlast sample the histogram is scanned and one
// result (earliest most frequent interval and its count) leaves on the
// m_axis channel; the tape state then returns to its reset values.
// Processing: the tracks of a taken sample are visited one a cycle
// through one shared subtract/compare unit, except that each edge whose
// interval falls inside the bucket range holds the visit for a
// read-modify-write on the single histogram memory.
// A tlast sample adds a scan over the whole memory (which also zeroes it)
// and a load of the output register. After reset the memory is cleared
// in one pass, tready low. The result sits in an output register; new
// samples are still taken while it waits, and the next result stalls,
// tready low, until it is taken. The user writes bucket_count through
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module pulse_interval_histogram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: bucket_count
  input  logic                      cfg_we_i,
  input  logic [pih_pkg::CfgW-1:0]  cfg_wdata_i,
  // sample stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // [8:0] track_bits
  input  logic                      s_axis_tlast,  // end_of_tape
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata   // [9:0] mode_interval, [41:10] mode_count
);
  import pih_pkg::*;

  localparam logic [PositionBits-1:0] PosMax    = '1;
  localparam logic [CountW-1:0]       CountMax  = '1;
  localparam logic [ScanIdxW-1:0]     ScanEnd   = ScanIdxW'(MaxBuckets);
  localparam logic [ScanIdxW-1:0]     ClearLast = ScanIdxW'(MaxBuckets - 1);
  localparam logic [TrackIdxW-1:0]    TrackLast = TrackIdxW'(Tracks - 1);
  localparam logic [CfgW-1:0]         BucketMax = CfgW'(MaxBuckets);

  pih_state_e state_q, state_d;

  logic [CfgW-1:0]         bucket_q, bucket_d;
  logic [Tracks-1:0]       prior_q, prior_d;
  logic [Tracks-1:0]       edges_q, edges_d;
  logic                    tape_end_q, tape_end_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] last_edge_q [Tracks];
  logic [PositionBits-1:0] last_edge_d [Tracks];
  logic [TrackIdxW-1:0]    trk_q, trk_d;
  logic [ScanIdxW-1:0]     idx_q, idx_d;
  logic [BucketIdxW-1:0]   len_q, len_d;
  logic                    pend_q, pend_d;
  logic [BucketIdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [CountW-1:0]       best_n_q, best_n_d;
  logic [BucketIdxW-1:0]   best_i_q, best_i_d;
  logic                    out_valid_q, out_valid_d;
  logic [IntervalW-1:0]    out_int_q, out_int_d;
  logic [CountW-1:0]       out_cnt_q, out_cnt_d;

  ram_req_t          ram_req;
  logic [CountW-1:0] ram_rd;

  logic [CfgW-1:0]         nb;
  logic [PositionBits-1:0] len;
  logic                    in_range;
  logic                    trk_done;

  pih_hist_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

  // buckets in use, capped at the memory depth
  assign nb = (bucket_q > BucketMax) ? BucketMax : bucket_q;

  // shared interval unit: distance from the current track's last edge
  assign len      = pos_q - last_edge_q[trk_q];
  assign in_range = len < PositionBits'(nb);
  assign trk_done = trk_q == TrackLast;

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_cnt_q, out_int_q};

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    bucket_d    = bucket_q;
    prior_d     = prior_q;
    edges_d     = edges_q;
    tape_end_d  = tape_end_q;
    pos_d       = pos_q;
    last_edge_d = last_edge_q;
    trk_d       = trk_q;
    idx_d       = idx_q;
    len_d       = len_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    best_n_d    = best_n_q;
    best_i_d    = best_i_q;
    out_valid_d = out_valid_q;
    out_int_d   = out_int_q;
    out_cnt_d   = out_cnt_q;

    ram_req       = '0;
    ram_req.waddr = len_q;
    ram_req.raddr = len[BucketIdxW-1:0];

    if (cfg_we_i) begin
      bucket_d = cfg_wdata_i;
    end
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // zero the histogram after reset
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q[BucketIdxW-1:0];
        ram_req.wdata = '0;
        idx_d         = idx_q + 1'b1;
        if (idx_q == ClearLast) begin
          state_d = ST_IDLE;
        end
      end

      // take a sample and latch its rising edges
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          edges_d    = s_axis_tdata[Tracks-1:0] & ~prior_q;
          prior_d    = s_axis_tdata[Tracks-1:0];
          tape_end_d = s_axis_tlast;
          trk_d      = '0;
          state_d    = ST_EDGE;
        end
      end

      // visit one track: time its edge and read the bucket
      ST_EDGE: begin
        if (edges_q[trk_q]) begin
          last_edge_d[trk_q] = pos_q;
        end
        if (edges_q[trk_q] && in_range) begin
          ram_req.re = 1'b1;
          len_d      = len[BucketIdxW-1:0];
          state_d    = ST_WRITE;
        end else if (!trk_done) begin
          trk_d = trk_q + 1'b1;
        end else begin
          if (pos_q != PosMax) begin
            pos_d = pos_q + 1'b1;
          end
          state_d = tape_end_q ? ST_SCAN : ST_IDLE;
          idx_d   = '0;
        end
      end

      // saturating increment of the bucket read in the previous cycle
      ST_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = (ram_rd == CountMax) ? ram_rd : ram_rd + 1'b1;
        if (!trk_done) begin
          trk_d   = trk_q + 1'b1;
          state_d = ST_EDGE;
        end else begin
          if (pos_q != PosMax) begin
            pos_d = pos_q + 1'b1;
          end
          state_d = tape_end_q ? ST_SCAN : ST_IDLE;
          idx_d   = '0;
        end
      end

      // read every bucket, keep the earliest maximum of those in use, zero behind the read
      ST_SCAN: begin
        if (idx_q == '0) begin
          best_n_d = '0;
          best_i_d = '0;
          prior_d  = '1;
          pos_d    = '0;
          for (int t = 0; t < Tracks; t++) begin
            last_edge_d[t] = '0;
          end
        end
        if (idx_q != ScanEnd) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_q[BucketIdxW-1:0];
          pend_d        = 1'b1;
          pend_idx_d    = idx_q[BucketIdxW-1:0];
          idx_d         = idx_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
        if (pend_q) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pend_idx_q;
          ram_req.wdata = '0;
          if ((CfgW'(pend_idx_q) < nb) && (ram_rd > best_n_q)) begin
            best_n_d = ram_rd;
            best_i_d = pend_idx_q;
          end
        end
      end

      // load the result once the output register is free
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_int_d   = IntervalW'(best_i_q);
          out_cnt_d   = best_n_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // control and tape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q    <= BucketMax;
      prior_q     <= '1;
      pos_q       <= '0;
      for (int t = 0; t < Tracks; t++) begin
        last_edge_q[t] <= '0;
      end
      trk_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bucket_q    <= bucket_d;
      prior_q     <= prior_d;
      pos_q       <= pos_d;
      last_edge_q <= last_edge_d;
      trk_q       <= trk_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    edges_q    <= edges_d;
    tape_end_q <= tape_end_d;
    len_q      <= len_d;
    pend_idx_q <= pend_idx_d;
    best_n_q   <= best_n_d;
    best_i_q   <= best_i_d;
    out_int_q  <= out_int_d;
    out_cnt_q  <= out_cnt_d;
  end

endmodule

FILE: tb/sv/tb_pulse_interval_histogram.sv
// Self-checking testbench for pulse_interval_histogram: directed tapes, then random
// tapes under four idling phases, all checked against an in-bench histogram model.
// Depends on pih_pkg and the pulse_interval_histogram rtl.
`timescale 1ns / 100ps

module tb_pulse_interval_histogram;
  import pih_pkg::*;

  typedef struct packed {
    logic [IntervalW-1:0] mode_interval;
    logic [CountW-1:0]    mode_count;
  } mode_result_t;

  typedef enum logic {
    TAPE_PERIODIC,
    TAPE_NOISE
  } tape_style_e;

  localparam int DrainCycles = 40;
  localparam int ShowLimit   = 10;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CfgW-1:0]  cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;  // [8:0] track_bits
  logic             s_axis_tlast  = 1'b0;  // end_of_tape
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;  // [9:0] mode_interval, [41:10] mode_count

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int samples_sent       = 0;
  int tapes_sent         = 0;
  int modes_checked      = 0;
  int error_count        = 0;

  // histogram model state
  logic [CfgW-1:0]         hist_buckets = CfgW'(MaxBuckets);
  logic [Tracks-1:0]       hist_prior;
  logic [PositionBits-1:0] hist_position;
  logic [PositionBits-1:0] hist_last_edge [Tracks];
  logic [CountW-1:0]       hist_counts [MaxBuckets];
  mode_result_t            pending_modes [$];
  mode_result_t            oldest_mode;

  pulse_interval_histogram uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic void log_error(string msg);
    if (error_count < ShowLimit) begin
      $display("%0t: %s", $realtime, msg);
    end
    error_count++;
  endfunction

  function automatic void clear_histogram();
    hist_prior    = '1;
    hist_position = '0;
    foreach (hist_last_edge[c]) hist_last_edge[c] = '0;
    foreach (hist_counts[i]) hist_counts[i] = '0;
  endfunction

  // update the histogram with one sample; a tape end queues the mode
  function automatic void tally_sample(logic [Tracks-1:0] track_bits, logic eot);
    logic [Tracks-1:0]       edges;
    logic [PositionBits-1:0] span;
    int unsigned             in_use;
    mode_result_t            mode;
    in_use = (hist_buckets > MaxBuckets) ? MaxBuckets : hist_buckets;
    edges  = track_bits & ~hist_prior;
    for (int c = 0; c < Tracks; c++) begin
      if (edges[c]) begin
        span = hist_position - hist_last_edge[c];
        if (span < in_use && hist_counts[span] != '1) begin
          hist_counts[span]++;
        end
        hist_last_edge[c] = hist_position;
      end
    end
    hist_prior = track_bits;
    if (hist_position != '1) begin
      hist_position++;
    end
    if (eot) begin
      mode = '0;
      // earliest bucket wins ties, so only a strictly larger count replaces
      for (int i = 0; i < in_use; i++) begin
        if (hist_counts[i] > mode.mode_count) begin
          mode.mode_count    = hist_counts[i];
          mode.mode_interval = IntervalW'(i);
        end
      end
      pending_modes.push_back(mode);
      clear_histogram();
    end
  endfunction

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [Tracks-1:0] track_bits, input logic eot);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 16'(track_bits);
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    tally_sample(track_bits, eot);
    samples_sent++;
    if (eot) begin
      tapes_sent++;
    end
  endtask

  // stop sending, wait for every pending result, then let the last sample finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_buckets(input logic [CfgW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    hist_buckets = value;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] random_buckets();
    case ($urandom_range(6))
      0:       return '0;
      1:       return CfgW'(1);
      2:       return CfgW'(MaxBuckets);
      3:       return '1;
      4:       return CfgW'($urandom());
      default: return CfgW'($urandom_range(2, 32));
    endcase
  endfunction

  // one tape: mostly per-track pulse trains with a little noise, some pure noise
  task automatic random_tape(output int sent);
    int unsigned       length;
    tape_style_e       style;
    bit                retune;
    int unsigned       period [Tracks];
    int unsigned       offset [Tracks];
    int unsigned       high [Tracks];
    logic [Tracks-1:0] track_bits;
    length = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    style  = ($urandom_range(9) < 7) ? TAPE_PERIODIC : TAPE_NOISE;
    retune = ($urandom_range(9) == 0);
    for (int c = 0; c < Tracks; c++) begin
      period[c] = $urandom_range(2, 9);
      offset[c] = $urandom_range(0, period[c] - 1);
      high[c]   = $urandom_range(1, period[c] - 1);
    end
    for (int unsigned pos = 0; pos < length; pos++) begin
      if (retune && pos == length / 2) begin
        write_buckets(random_buckets());
      end
      if (style == TAPE_NOISE) begin
        track_bits = Tracks'($urandom());
      end else begin
        for (int c = 0; c < Tracks; c++) begin
          track_bits[c] = ((pos + offset[c]) % period[c]) < high[c];
        end
        if ($urandom_range(19) == 0) begin
          track_bits[$urandom_range(Tracks - 1)] ^= 1'b1;
        end
      end
      send_sample(track_bits, pos == length - 1);
    end
    sent = length;
  endtask

  task automatic run_random_phase(int idle_pct, int stall_pct, int items, bit vary_buckets);
    int sent;
    int total;
    total              = 0;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (total < items) begin
      if (vary_buckets) begin
        write_buckets(random_buckets());
      end
      random_tape(sent);
      total += sent;
    end
  endtask

  // all tracks rise on the third sample; the first sample never has an edge
  task automatic test_first_sample_and_extremes();
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
  endtask

  task automatic test_empty_tape();
    send_sample('0, 1'b1);
    send_sample('1, 1'b0);
    send_sample('1, 1'b1);
  endtask

  // intervals 3, 4 and 2 each once: the earliest bucket must win
  task automatic test_earliest_tie();
    send_sample(9'h000, 1'b0);
    send_sample(9'h000, 1'b0);
    send_sample(9'h000, 1'b0);
    send_sample(9'h001, 1'b0);
    send_sample(9'h002, 1'b0);
    send_sample(9'h001, 1'b1);
  endtask

  // zero, one, two and oversized bucket counts on interval-one edges
  task automatic test_bucket_limits();
    write_buckets('0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    write_buckets(CfgW'(1));
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    write_buckets(CfgW'(2));
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    write_buckets('1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
  endtask

  // a large bucket filled early is hidden by a smaller count set mid-tape
  task automatic test_bucket_change_mid_tape();
    write_buckets(CfgW'(MaxBuckets));
    repeat (5) send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    write_buckets(CfgW'(3));
    send_sample(9'h000, 1'b0);
    send_sample(9'h001, 1'b0);
    send_sample(9'h000, 1'b1);
  endtask

  task automatic test_random_no_idling();
    write_buckets(CfgW'(MaxBuckets));
    run_random_phase(0, 0, 110, 1'b0);
  endtask

  task automatic test_random_sender_gaps();
    write_buckets(CfgW'($urandom_range(4, 24)));
    run_random_phase(70, 0, 110, 1'b0);
  endtask

  task automatic test_random_receiver_stalls();
    write_buckets('1);
    run_random_phase(0, 70, 110, 1'b0);
  endtask

  task automatic test_random_mixed_buckets();
    run_random_phase(17, 17, 110, 1'b1);
  endtask

  // result side: random stalls on tready
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // compare each accepted result with the oldest pending mode
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_modes.size() == 0) begin
        log_error($sformatf("result with nothing pending: tdata %h", m_axis_tdata));
      end else begin
        oldest_mode = pending_modes.pop_front();
        modes_checked++;
        if (m_axis_tdata[IntervalW-1:0] !== oldest_mode.mode_interval) begin
          log_error($sformatf("mode_interval: expected %0d, got %0d",
                              oldest_mode.mode_interval, m_axis_tdata[IntervalW-1:0]));
        end
        if (m_axis_tdata[IntervalW +: CountW] !== oldest_mode.mode_count) begin
          log_error($sformatf("mode_count: expected %0d, got %0d",
                              oldest_mode.mode_count, m_axis_tdata[IntervalW +: CountW]));
        end
      end
    end
  end

  initial begin
    clear_histogram();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_sample_and_extremes();
    test_empty_tape();
    test_earliest_tie();
    test_bucket_limits();
    test_bucket_change_mid_tape();
    test_random_no_idling();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_mixed_buckets();
    drain();
    $display("sent %0d samples in %0d tapes, checked %0d histogram modes",
             samples_sent, tapes_sent, modes_checked);
    $display("bucket counts from 0 to 2047, sender gaps and result stalls, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", pending_modes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
